// ===== rtl/sbe_pkg.sv =====
// Package for the stack bytecode executor.
// Holds the stack size, opcode and error codes, and the cell control types.
// No dependencies.
`timescale 1ns / 1ps

package sbe_pkg;

	// Stack geometry
	localparam int STACK_DEPTH = 128;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 64;

	// Instruction opcodes
	localparam logic [2:0] BC_PUSH  = 3'd0;
	localparam logic [2:0] BC_PRINT = 3'd1;
	localparam logic [2:0] BC_READ  = 3'd2;
	localparam logic [2:0] BC_IADD  = 3'd3;
	localparam logic [2:0] BC_STOP  = 3'd4;

	// Error codes reported with each result
	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_NO_READ     = 3'd1;
	localparam logic [2:0] ERR_ADD_UNDER   = 3'd2;
	localparam logic [2:0] ERR_PRINT_UNDER = 3'd3;
	localparam logic [2:0] ERR_OVERFLOW    = 3'd4;

	// What a stack cell loads on a clock edge
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_TAKE_UP,
		CELL_TAKE_DOWN
	} cell_cmd_t;

	// Commands broadcast to the cell row: the top cell has its own
	typedef struct packed {
		cell_cmd_t top_cmd;
		cell_cmd_t rest_cmd;
	} cell_ctrl_t;

endpackage

// ===== rtl/stack_bytecode_executor.sv =====
// Stack bytecode executor: top level with the instruction decoder and the cell row.
// Depends on sbe_pkg and sbe_cell.
//
// Usage:
// - The input channel (in_valid, in_stall) carries one instruction per beat:
//   operation, immediate, read_value and read_present.
// - The output channel (out_valid, out_stall) returns one result beat per
//   instruction: print_value, print_valid, error_code and halted.
// - The result of an instruction is registered: it is shown in the cycle after
//   the instruction is accepted. One instruction per cycle is taken while no
//   result waits under out_stall.
// - The stack is a row of 64-bit cells, top entry in cell 0. Every instruction
//   shifts the whole row by at most one place, and add reads cells 0 and 1
//   directly, so no instruction waits on a memory port.
// - The result sits in an output register. While a result waits under
//   out_stall, in_stall is raised and no new instruction is taken; once it is
//   taken, the next instruction is accepted in the same cycle.
// - Reset empties the stack and clears the halt flag and the output valid flag.
//   No clearing pass is needed; the block takes items right after reset.
// - After stop or an error, instructions are still accepted but ignored, and
//   each reports halted until the next reset.
`timescale 1ns / 1ps

module stack_bytecode_executor
	import sbe_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               operation,
	input  logic signed [DATA_W-1:0] immediate,
	input  logic signed [DATA_W-1:0] read_value,
	input  logic                     read_present,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] print_value,
	output logic                     print_valid,
	output logic [2:0]               error_code,
	output logic                     halted
);

	logic               accept;
	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] depth_next;
	logic               halt_q;
	logic               halt_next;
	logic               full;
	logic [DATA_W-1:0]  push_data;
	logic [DATA_W-1:0]  pval;
	logic               pvalid;
	logic [2:0]         err;
	cell_ctrl_t         ctrl;
	cell_ctrl_t         ctrl_gated;
	logic [DATA_W-1:0]  cell_value [STACK_DEPTH];

	logic               out_valid_q;
	logic [DATA_W-1:0]  print_value_q;
	logic               print_valid_q;
	logic [2:0]         error_code_q;
	logic               halted_q;

	// Handshake: hold off new beats while a result is stuck at the output.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (depth_q == DEPTH_W'(STACK_DEPTH));

	// Instruction decode: stack movement, result and next depth.
	always_comb begin
		ctrl.top_cmd  = CELL_HOLD;
		ctrl.rest_cmd = CELL_HOLD;
		push_data     = immediate;
		pval          = '0;
		pvalid        = 1'b0;
		err           = ERR_NONE;
		depth_next    = depth_q;
		halt_next     = halt_q;
		if (!halt_q) begin
			case (operation)
				BC_PUSH: begin
					if (full) begin
						err = ERR_OVERFLOW;
					end else begin
						ctrl.top_cmd  = CELL_TAKE_UP;
						ctrl.rest_cmd = CELL_TAKE_UP;
						depth_next    = depth_q + DEPTH_W'(1);
					end
				end
				BC_READ: begin
					push_data = read_value;
					if (!read_present) begin
						err = ERR_NO_READ;
					end else if (full) begin
						err = ERR_OVERFLOW;
					end else begin
						ctrl.top_cmd  = CELL_TAKE_UP;
						ctrl.rest_cmd = CELL_TAKE_UP;
						depth_next    = depth_q + DEPTH_W'(1);
					end
				end
				BC_IADD: begin
					push_data = cell_value[0] + cell_value[1];
					if (depth_q < DEPTH_W'(2)) begin
						err = ERR_ADD_UNDER;
					end else begin
						ctrl.top_cmd  = CELL_TAKE_UP;
						ctrl.rest_cmd = CELL_TAKE_DOWN;
						depth_next    = depth_q - DEPTH_W'(1);
					end
				end
				BC_PRINT: begin
					if (depth_q == '0) begin
						err = ERR_PRINT_UNDER;
					end else begin
						ctrl.top_cmd  = CELL_TAKE_DOWN;
						ctrl.rest_cmd = CELL_TAKE_DOWN;
						pval          = cell_value[0];
						pvalid        = 1'b1;
						depth_next    = depth_q - DEPTH_W'(1);
					end
				end
				BC_STOP: begin
					halt_next = 1'b1;
				end
				default: begin
				end
			endcase
			if (err != ERR_NONE) begin
				halt_next = 1'b1;
			end
		end
	end

	// The row moves only on an accepted beat.
	always_comb begin
		ctrl_gated = ctrl;
		if (!accept) begin
			ctrl_gated.top_cmd  = CELL_HOLD;
			ctrl_gated.rest_cmd = CELL_HOLD;
		end
	end

	// Row of stack cells, top of stack in cell 0.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] up_in;
		logic [DATA_W-1:0] down_in;
		if (i == 0) begin : g_top
			assign up_in = push_data;
		end else begin : g_mid
			assign up_in = cell_value[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign down_in = '0;
		end else begin : g_inner
			assign down_in = cell_value[i+1];
		end
		sbe_cell u_cell (
			.clk       (clk),
			.cmd       ((i == 0) ? ctrl_gated.top_cmd : ctrl_gated.rest_cmd),
			.up_data   (up_in),
			.down_data (down_in),
			.value     (cell_value[i])
		);
	end

	// Stack depth and halt flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			halt_q  <= 1'b0;
		end else if (accept) begin
			depth_q <= depth_next;
			halt_q  <= halt_next;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			print_value_q <= pval;
			print_valid_q <= pvalid;
			error_code_q  <= err;
			halted_q      <= halt_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign print_value = print_value_q;
	assign print_valid = print_valid_q;
	assign error_code  = error_code_q;
	assign halted      = halted_q;

	// The depth never runs past the number of cells.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_DEPTH))
		else $error("stack depth beyond cell count");

	// Once halted, the machine stays halted.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared without reset");

	// A halted machine leaves the stack depth alone.
	a_halt_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && halt_q) |=> $stable(depth_q))
		else $error("stack moved after halt");

	// Any reported error comes with halted set.
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && error_code_q != ERR_NONE) |-> halted_q)
		else $error("error reported without halt");

	// A printed value never comes with an error.
	a_print_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && print_valid_q) |-> (error_code_q == ERR_NONE))
		else $error("print result carries an error");

endmodule

// ===== rtl/sbe_cell.sv =====
// One entry of the stack, built as a cell of a shifting row.
// Depends on sbe_pkg for the data width and the cell command type.
`timescale 1ns / 1ps

module sbe_cell
	import sbe_pkg::*;
(
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [DATA_W-1:0] up_data,
	input  logic [DATA_W-1:0] down_data,
	output logic [DATA_W-1:0] value
);

	logic [DATA_W-1:0] value_q;

	// Take the neighbor toward the top on a push, the one below on a pop.
	always_ff @(posedge clk) begin
		case (cmd)
			CELL_TAKE_UP:   value_q <= up_data;
			CELL_TAKE_DOWN: value_q <= down_data;
			CELL_HOLD:      value_q <= value_q;
			default:        value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for stack_bytecode_executor: random and directed instruction streams,
// a clocked driver and monitor, and a predictor of the data stack run on each accepted beat.
// Depends on sbe_pkg and the stack_bytecode_executor RTL.
`timescale 1ns / 1ps

module tb_top
	import sbe_pkg::*;
;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int TAIL_ITEMS   = 150;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int AFTER_HALT   = 20;
	localparam int IDX_W        = $clog2(STACK_DEPTH);

	// Opcodes the block treats as no-ops
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

	// Ways the run is brought to its single halt
	typedef enum int {
		END_BY_STOP,
		END_BY_NO_READ,
		END_BY_ADD_UNDER,
		END_BY_PRINT_UNDER,
		END_BY_OVERFLOW
	} halt_kind_t;

	localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct {
		logic [2:0]        op;
		logic [DATA_W-1:0] imm;
		logic [DATA_W-1:0] rval;
		logic              rpres;
	} instr_t;

	typedef struct {
		logic [DATA_W-1:0] pval;
		logic              pvalid;
		logic [2:0]        err;
		logic              halt;
	} outcome_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     in_valid     = 1'b0;
	logic                     in_stall;
	logic [2:0]               operation    = BC_PUSH;
	logic signed [DATA_W-1:0] immediate    = '0;
	logic signed [DATA_W-1:0] read_value   = '0;
	logic                     read_present = 1'b0;
	logic                     out_valid;
	logic                     out_stall    = 1'b0;
	logic signed [DATA_W-1:0] print_value;
	logic                     print_valid;
	logic [2:0]               error_code;
	logic                     halted;

	// Instruction stream and expected outcomes
	instr_t   pending[$];
	outcome_t outcome_q[$];
	instr_t   cur;
	outcome_t want;

	// Predicted machine state
	logic [DATA_W-1:0] stk [STACK_DEPTH];
	int                sp          = 0;
	logic              mach_halted = 1'b0;

	// Stack depth as seen while the stream is generated
	int gen_sp = 0;

	int n_total    = 0;
	int n_accepted = 0;
	int n_results  = 0;
	int n_errors   = 0;
	int cycles     = 0;

	int   tx_gap     = 0;
	int   tx_calm    = 0;
	int   rx_burst   = 0;
	int   rx_calm    = 0;
	int   hold_count = 0;
	logic long_hold  = 1'b0;
	logic quiet;

	stack_bytecode_executor i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.immediate    (immediate),
		.read_value   (read_value),
		.read_present (read_present),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.print_value  (print_value),
		.print_valid  (print_valid),
		.error_code   (error_code),
		.halted       (halted)
	);

	// Free-running clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// No idling during the last stretch of the run.
	assign quiet = (n_accepted + TAIL_ITEMS >= n_total);

	// Executes one instruction on the predicted stack and returns its outcome.
	function automatic outcome_t execute_instr(instr_t it);
		outcome_t res;
		res = '{pval: '0, pvalid: 1'b0, err: ERR_NONE, halt: 1'b0};
		if (!mach_halted) begin
			case (it.op)
				BC_PUSH: begin
					if (sp >= STACK_DEPTH) begin
						res.err = ERR_OVERFLOW;
					end else begin
						stk[IDX_W'(sp)] = it.imm;
						sp++;
					end
				end
				BC_READ: begin
					if (!it.rpres) begin
						res.err = ERR_NO_READ;
					end else if (sp >= STACK_DEPTH) begin
						res.err = ERR_OVERFLOW;
					end else begin
						stk[IDX_W'(sp)] = it.rval;
						sp++;
					end
				end
				BC_IADD: begin
					if (sp < 2) begin
						res.err = ERR_ADD_UNDER;
					end else begin
						stk[IDX_W'(sp-2)] = stk[IDX_W'(sp-1)] + stk[IDX_W'(sp-2)];
						sp--;
					end
				end
				BC_PRINT: begin
					if (sp < 1) begin
						res.err = ERR_PRINT_UNDER;
					end else begin
						sp--;
						res.pval   = stk[IDX_W'(sp)];
						res.pvalid = 1'b1;
					end
				end
				BC_STOP: begin
					mach_halted = 1'b1;
				end
				default: begin
				end
			endcase
			if (res.err != ERR_NONE)
				mach_halted = 1'b1;
		end
		res.halt = mach_halted;
		return res;
	endfunction

	// Random 64-bit word with the extremes drawn often.
	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '1;
			3: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Appends one instruction and tracks the stack depth it leaves behind.
	task automatic queue_instr(logic [2:0] op, logic [DATA_W-1:0] imm, logic [DATA_W-1:0] rval,
			logic rpres);
		instr_t it;
		it.op    = op;
		it.imm   = imm;
		it.rval  = rval;
		it.rpres = rpres;
		pending.push_back(it);
		if (op == BC_PUSH || (op == BC_READ && rpres))
			gen_sp++;
		else if ((op == BC_IADD && gen_sp >= 2) || (op == BC_PRINT && gen_sp >= 1))
			gen_sp--;
	endtask

	// One entry more: a push or a read that carries its value.
	task automatic queue_up();
		if ($urandom_range(0, 1))
			queue_instr(BC_PUSH, rand_word(), rand_word(), 1'($urandom_range(0, 1)));
		else
			queue_instr(BC_READ, rand_word(), rand_word(), 1'b1);
	endtask

	// One entry less: an add or a print.
	task automatic queue_down();
		if (gen_sp >= 2 && $urandom_range(0, 1))
			queue_instr(BC_IADD, rand_word(), rand_word(), 1'($urandom_range(0, 1)));
		else
			queue_instr(BC_PRINT, rand_word(), rand_word(), 1'($urandom_range(0, 1)));
	endtask

	// Stream generation, reset and end of run.
	initial begin
		int         n_rand;
		int         target;
		int         keep;
		logic       go_up;
		halt_kind_t ending;

		// Directed: wrapping sums at the extremes, reads, no-op codes.
		queue_instr(BC_PUSH, WORD_MAX, '0, 1'b0);
		queue_instr(BC_PUSH, 64'd1, '1, 1'b1);
		queue_instr(BC_IADD, '0, '0, 1'b0);
		queue_instr(BC_PRINT, '1, '1, 1'b1);
		queue_instr(BC_PUSH, WORD_MIN, '0, 1'b0);
		queue_instr(BC_PUSH, WORD_MIN, '0, 1'b0);
		queue_instr(BC_IADD, '1, '1, 1'b1);
		queue_instr(BC_PRINT, '0, '0, 1'b0);
		queue_instr(BC_READ, '0, '1, 1'b1);
		queue_instr(BC_READ, '1, '0, 1'b1);
		queue_instr(BC_IADD, '0, '0, 1'b0);
		queue_instr(BC_PRINT, '0, '0, 1'b0);
		queue_instr(OP_UNUSED_FIRST, rand_word(), rand_word(), 1'b0);
		queue_instr(3'(OP_UNUSED_FIRST + 3'd1), rand_word(), rand_word(), 1'b1);
		queue_instr(OP_UNUSED_LAST, rand_word(), rand_word(), 1'b0);
		queue_instr(BC_READ, '0, WORD_MAX, 1'b1);
		queue_instr(BC_PUSH, '1, '0, 1'b0);
		queue_instr(BC_IADD, '0, '0, 1'b1);
		queue_instr(BC_PRINT, '0, '0, 1'b0);
		queue_instr(BC_PUSH, '0, WORD_MIN, 1'b0);
		queue_instr(BC_PRINT, WORD_MIN, WORD_MAX, 1'b1);

		// Random walk of the stack depth toward changing targets, empty and full among them.
		n_rand = 0;
		target = STACK_DEPTH;
		while (n_rand < RANDOM_ITEMS) begin
			if (gen_sp == target) begin
				case ($urandom_range(0, 3))
					0: target = STACK_DEPTH;
					1: target = 0;
					default: target = $urandom_range(0, STACK_DEPTH);
				endcase
			end
			if ($urandom_range(0, 19) == 0) begin
				queue_instr(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), rand_word(),
					rand_word(), 1'($urandom_range(0, 1)));
			end else begin
				if (gen_sp < target)
					go_up = ($urandom_range(0, 3) != 0);
				else
					go_up = ($urandom_range(0, 3) == 0);
				if (gen_sp == 0)
					go_up = 1'b1;
				if (gen_sp >= STACK_DEPTH)
					go_up = 1'b0;
				if (go_up)
					queue_up();
				else
					queue_down();
				n_rand++;
			end
		end

		// The run ends in one halt, picked at random.
		ending = halt_kind_t'($urandom_range(END_BY_STOP, END_BY_OVERFLOW));
		case (ending)
			END_BY_STOP: begin
				queue_instr(BC_STOP, rand_word(), rand_word(), 1'($urandom_range(0, 1)));
			end
			END_BY_NO_READ: begin
				queue_instr(BC_READ, rand_word(), rand_word(), 1'b0);
			end
			END_BY_ADD_UNDER: begin
				keep = $urandom_range(0, 1);
				while (gen_sp > keep)
					queue_instr(BC_PRINT, rand_word(), rand_word(), 1'($urandom_range(0, 1)));
				queue_instr(BC_IADD, rand_word(), rand_word(), 1'($urandom_range(0, 1)));
			end
			END_BY_PRINT_UNDER: begin
				while (gen_sp > 0)
					queue_down();
				queue_instr(BC_PRINT, rand_word(), rand_word(), 1'($urandom_range(0, 1)));
			end
			default: begin
				while (gen_sp < STACK_DEPTH)
					queue_up();
				queue_up();
			end
		endcase

		// Everything after the halt must come back as halted.
		repeat (AFTER_HALT)
			queue_instr(3'($urandom_range(0, 7)), rand_word(), rand_word(),
				1'($urandom_range(0, 1)));
		n_total = pending.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_total)
			@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(string msg);
		$display("MISMATCH: %s", msg);
		n_errors++;
	endtask

	// Driver: predicts each accepted beat, then offers the next one or a gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			operation    <= BC_PUSH;
			immediate    <= '0;
			read_value   <= '0;
			read_present <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				outcome_q.push_back(execute_instr(cur));
				n_accepted <= n_accepted + 1;
			end
			if (tx_calm > 0)
				tx_calm--;
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					cur = pending.pop_front();
					operation    <= cur.op;
					immediate    <= cur.imm;
					read_value   <= cur.rval;
					read_present <= cur.rpres;
					in_valid     <= 1'b1;
					if (!quiet && !long_hold && tx_calm == 0 && $urandom_range(0, 9) == 0) begin
						tx_gap = $urandom_range(1, 19);
						if ($urandom_range(0, 15) == 0)
							tx_calm = $urandom_range(40, 160);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, once, so that the block backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold <= 1'b0;
		end else if (hold_count <= HOLD_CYCLES && (hold_count > 0 || n_accepted >= HOLD_AT)) begin
			long_hold  <= (hold_count < HOLD_CYCLES);
			hold_count <= hold_count + 1;
		end
	end

	// Monitor: checks each accepted result beat and drives the receiver stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (outcome_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing pending",
						n_results));
				end else begin
					want = outcome_q.pop_front();
					if (print_value !== want.pval)
						report_mismatch($sformatf("result %0d print_value %h, expected %h",
							n_results, print_value, want.pval));
					if (print_valid !== want.pvalid)
						report_mismatch($sformatf("result %0d print_valid %b, expected %b",
							n_results, print_valid, want.pvalid));
					if (error_code !== want.err)
						report_mismatch($sformatf("result %0d error_code %0d, expected %0d",
							n_results, error_code, want.err));
					if (halted !== want.halt)
						report_mismatch($sformatf("result %0d halted %b, expected %b",
							n_results, halted, want.halt));
				end
			end
			if (rx_calm > 0)
				rx_calm--;
			if (rx_burst > 0) begin
				rx_burst--;
			end else if (!quiet && rx_calm == 0 && $urandom_range(0, 9) == 0) begin
				rx_burst = $urandom_range(1, 19);
				if ($urandom_range(0, 15) == 0)
					rx_calm = $urandom_range(40, 160);
			end
			out_stall <= long_hold || (rx_burst > 0);
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

endmodule
